// File: design/tqsp_pkg.sv
// Shared types and constants of the timestamp query slot pool.
package tqsp_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned HANDLE_W = 7;
	localparam int unsigned TICK_W   = 64;
	localparam int unsigned STATUS_W = 2;

	// Depth of the queue between the front and the back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE  = 2'd0,
		CMD_RECORD  = 2'd1,
		CMD_RESOLVE = 2'd2,
		CMD_DESTROY = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 2'd0,
		ST_INVALID      = 2'd1,
		ST_NOT_RECORDED = 2'd2,
		ST_FULL         = 2'd3
	} status_t;

	// Classified command as it travels from the front to the back
	typedef struct packed {
		cmd_t                command;
		logic                handle_ok;
		logic [HANDLE_W-1:0] slot_idx;
		logic [TICK_W-1:0]   tick;
	} op_t;

endpackage

// File: design/tqsp_cmd_if.sv
// Command channel interface: valid/ready with one command transaction.
interface tqsp_cmd_if
	import tqsp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [HANDLE_W-1:0] query_handle;
	logic [TICK_W-1:0]   tick_value;

	modport source (output valid, output command, output query_handle, output tick_value,
		input ready);
	modport sink (input valid, input command, input query_handle, input tick_value,
		output ready);
endinterface

// File: design/tqsp_rsp_if.sv
// Result channel interface: valid/ready with one result transaction.
interface tqsp_rsp_if
	import tqsp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] new_handle;
	logic [TICK_W-1:0]   resolved_tick;

	modport source (output valid, output status, output new_handle, output resolved_tick,
		input ready);
	modport sink (input valid, input status, input new_handle, input resolved_tick,
		output ready);
endinterface

// File: design/tqsp_front.sv
// Front end: accept command transactions and classify their handles.
module tqsp_front
	import tqsp_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 64
) (
	tqsp_cmd_if.sink cmd,
	input  logic     queue_full,
	output logic     push,
	output op_t      push_op
);

	// Take a transaction whenever the queue has room
	assign cmd.ready = !queue_full;
	assign push      = cmd.valid && !queue_full;

	// Check the handle range and turn the handle into a zero-based index
	always_comb begin
		push_op.command   = cmd_t'(cmd.command);
		push_op.handle_ok = (cmd.query_handle != '0) &&
			(32'(cmd.query_handle) <= 32'(NUM_SLOTS));
		push_op.slot_idx  = cmd.query_handle - HANDLE_W'(1);
		push_op.tick      = cmd.tick_value;
	end

endmodule

// File: design/tqsp_queue.sv
// Short queue that decouples the front end from the back end.
module tqsp_queue
	import tqsp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output op_t  head_op
);

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_op   = entry_q[rd_ptr_q];

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// File: design/tqsp_back.sv
// Back end: execute commands on the slot table and hold the result register.
module tqsp_back
	import tqsp_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       op_valid,
	input  op_t        op,
	output logic       pop,
	tqsp_rsp_if.source rsp
);

	localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [NUM_SLOTS-1:0] in_use_q;
	logic [NUM_SLOTS-1:0] recorded_q;
	logic [TICK_W-1:0]    tick_mem [NUM_SLOTS];
	logic [TICK_W-1:0]    rd_tick_q;

	logic                 out_valid_q;
	status_t              status_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic                 tick_sel_q;

	logic                 exec;
	logic [SLOT_W-1:0]    idx;
	logic                 used;
	logic                 free_found;
	logic [SLOT_W-1:0]    free_idx;

	status_t              status_d;
	logic [HANDLE_W-1:0]  handle_d;
	logic                 tick_sel_d;
	logic                 mem_we;
	logic                 set_use;
	logic                 clr_use;
	logic                 set_rec;

	// Execute when a command waits and the result register is free or draining
	assign exec = op_valid && (!out_valid_q || rsp.ready);
	assign pop  = exec;
	assign idx  = op.slot_idx[SLOT_W-1:0];
	assign used = op.handle_ok && in_use_q[idx];

	// Find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	// Decode the command into a result and table updates
	always_comb begin
		status_d   = ST_OK;
		handle_d   = '0;
		tick_sel_d = 1'b0;
		mem_we     = 1'b0;
		set_use    = 1'b0;
		clr_use    = 1'b0;
		set_rec    = 1'b0;
		unique case (op.command)
			CMD_CREATE: begin
				if (free_found) begin
					handle_d = HANDLE_W'(free_idx) + HANDLE_W'(1);
					set_use  = 1'b1;
				end else begin
					status_d = ST_FULL;
				end
			end
			CMD_RECORD: begin
				if (!used) begin
					status_d = ST_INVALID;
				end else begin
					mem_we  = 1'b1;
					set_rec = 1'b1;
				end
			end
			CMD_RESOLVE: begin
				if (!used) begin
					status_d = ST_INVALID;
				end else if (recorded_q[idx]) begin
					tick_sel_d = 1'b1;
				end else begin
					status_d = ST_NOT_RECORDED;
				end
			end
			CMD_DESTROY: begin
				if (!used) begin
					status_d = ST_INVALID;
				end else begin
					clr_use = 1'b1;
				end
			end
			default: begin
				status_d = ST_INVALID;
			end
		endcase
	end

	// Update slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q   <= '0;
			recorded_q <= '0;
		end else if (exec) begin
			if (set_use) begin
				in_use_q[free_idx]   <= 1'b1;
				recorded_q[free_idx] <= 1'b0;
			end
			if (clr_use) begin
				in_use_q[idx]   <= 1'b0;
				recorded_q[idx] <= 1'b0;
			end
			if (set_rec) begin
				recorded_q[idx] <= 1'b1;
			end
		end
	end

	// Write ticks and register the read for resolve
	always_ff @(posedge clk) begin
		if (exec && mem_we) begin
			tick_mem[idx] <= op.tick;
		end
		if (exec && tick_sel_d) begin
			rd_tick_q <= tick_mem[idx];
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q   <= status_d;
			handle_q   <= handle_d;
			tick_sel_q <= tick_sel_d;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.new_handle    = handle_q;
	assign rsp.resolved_tick = tick_sel_q ? rd_tick_q : '0;

endmodule

// File: design/timestamp_query_slot_pool_core.sv
// A command passes the queue, then the result register. Throughput: 1 command per cycle
// unless stalled; the back end executes one command per cycle against the slot flags and
// the single-port tick store, with a 2-entry queue behind the front end.
// Reset clears the slot flags at once (every slot free); the tick store is not cleared and
// needs no clearing pass, so commands are taken from the first cycle after reset.
// Top level: timestamp query slot pool with front end, queue and back end.
module timestamp_query_slot_pool_core
	import tqsp_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	tqsp_cmd_if.sink   cmd,
	tqsp_rsp_if.source rsp
);

	logic push;
	op_t  push_op;
	logic queue_full;
	logic queue_not_empty;
	op_t  head_op;
	logic pop;

	tqsp_front #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_front (
		.cmd        (cmd),
		.queue_full (queue_full),
		.push       (push),
		.push_op    (push_op)
	);

	tqsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head_op   (head_op)
	);

	tqsp_back #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (queue_not_empty),
		.op       (head_op),
		.pop      (pop),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	// A new result needs a command that waited in the queue
	a_result_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(queue_not_empty))
		else $error("result appeared without a queued command");

	// A handed-out handle names a real slot and comes with status ok
	a_handle_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.new_handle != '0) |->
			(32'(rsp.new_handle) <= 32'(NUM_SLOTS)) && (rsp.status == ST_OK))
		else $error("new handle out of range or with bad status");

	// A resolved tick never travels with a new handle or an error status
	a_tick_only_on_resolve: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.resolved_tick != '0) |->
			(rsp.status == ST_OK) && (rsp.new_handle == '0))
		else $error("resolved tick on a non-resolve result");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the timestamp query slot pool core.
module tb_top;
	import tqsp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned POOL_SLOTS  = 64;
	localparam int unsigned RANDOM_CMDS = 1750;
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	typedef struct {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [TICK_W-1:0]   tick;
	} pool_result_t;

	typedef struct {
		cmd_t                command;
		logic [HANDLE_W-1:0] handle;
		logic [TICK_W-1:0]   tick;
		logic                given;
		pool_result_t        result;
	} directed_row_t;

	logic clk;
	logic arst_n;

	tqsp_cmd_if cmd_ch ();
	tqsp_rsp_if rsp_ch ();

	timestamp_query_slot_pool_core #(
		.NUM_SLOTS(POOL_SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	// Shadow of the pool state
	logic                slot_used     [POOL_SLOTS];
	logic                slot_has_tick [POOL_SLOTS];
	logic [TICK_W-1:0]   slot_ticks    [POOL_SLOTS];

	pool_result_t pending_results [$];
	int unsigned  fail_count = 0;
	logic         steady     = 1'b0;

	// Directed commands: lifecycle of one and two slots, bad handles and overwrite
	directed_row_t directed_rows [21] = '{
		'{CMD_RESOLVE, 7'd1,   64'd0,    1'b1, '{ST_INVALID, 7'd0, 64'd0}},
		'{CMD_DESTROY, 7'd0,   64'd0,    1'b1, '{ST_INVALID, 7'd0, 64'd0}},
		'{CMD_RECORD,  7'd64,  TICK_MAX, 1'b1, '{ST_INVALID, 7'd0, 64'd0}},
		'{CMD_RESOLVE, 7'd127, TICK_MAX, 1'b1, '{ST_INVALID, 7'd0, 64'd0}},
		'{CMD_CREATE,  7'd127, TICK_MAX, 1'b1, '{ST_OK, 7'd1, 64'd0}},
		'{CMD_RESOLVE, 7'd1,   64'd0,    1'b1, '{ST_NOT_RECORDED, 7'd0, 64'd0}},
		'{CMD_RECORD,  7'd1,   TICK_MAX, 1'b1, '{ST_OK, 7'd0, 64'd0}},
		'{CMD_RESOLVE, 7'd1,   64'd0,    1'b1, '{ST_OK, 7'd0, TICK_MAX}},
		'{CMD_RECORD,  7'd1,   64'd0,    1'b1, '{ST_OK, 7'd0, 64'd0}},
		'{CMD_RESOLVE, 7'd1,   TICK_MAX, 1'b1, '{ST_OK, 7'd0, 64'd0}},
		'{CMD_CREATE,  7'd0,   64'd0,    1'b1, '{ST_OK, 7'd2, 64'd0}},
		'{CMD_RECORD,  7'd2,   64'h0123_4567_89ab_cdef, 1'b0, '{ST_OK, 7'd0, 64'd0}},
		'{CMD_RESOLVE, 7'd2,   64'd0,    1'b0, '{ST_OK, 7'd0, 64'd0}},
		'{CMD_DESTROY, 7'd1,   64'd0,    1'b1, '{ST_OK, 7'd0, 64'd0}},
		'{CMD_DESTROY, 7'd1,   64'd0,    1'b1, '{ST_INVALID, 7'd0, 64'd0}},
		'{CMD_RESOLVE, 7'd1,   64'd0,    1'b1, '{ST_INVALID, 7'd0, 64'd0}},
		'{CMD_CREATE,  7'd5,   64'd0,    1'b1, '{ST_OK, 7'd1, 64'd0}},
		'{CMD_RESOLVE, 7'd1,   64'd0,    1'b1, '{ST_NOT_RECORDED, 7'd0, 64'd0}},
		'{CMD_RECORD,  7'd65,  TICK_MAX, 1'b1, '{ST_INVALID, 7'd0, 64'd0}},
		'{CMD_DESTROY, 7'd2,   64'd0,    1'b0, '{ST_OK, 7'd0, 64'd0}},
		'{CMD_DESTROY, 7'd1,   64'd0,    1'b0, '{ST_OK, 7'd0, 64'd0}}
	};

	// Apply one command to the shadow pool and return the result it should give
	function automatic pool_result_t pool_apply(cmd_t command, logic [HANDLE_W-1:0] handle,
		logic [TICK_W-1:0] tick);
		pool_result_t res;
		int           idx;
		res = '{ST_OK, '0, '0};
		if (command == CMD_CREATE) begin
			res.status = ST_FULL;
			for (idx = 0; idx < POOL_SLOTS; idx++) begin
				if (!slot_used[idx]) begin
					slot_used[idx]     = 1'b1;
					slot_has_tick[idx] = 1'b0;
					res.status         = ST_OK;
					res.handle         = HANDLE_W'(idx + 1);
					break;
				end
			end
		end else if (handle == 0 || handle > POOL_SLOTS || !slot_used[handle - 1]) begin
			res.status = ST_INVALID;
		end else begin
			idx = int'(handle) - 1;
			case (command)
				CMD_RECORD: begin
					slot_ticks[idx]    = tick;
					slot_has_tick[idx] = 1'b1;
				end
				CMD_RESOLVE: begin
					if (slot_has_tick[idx])
						res.tick = slot_ticks[idx];
					else
						res.status = ST_NOT_RECORDED;
				end
				default: begin
					slot_used[idx]     = 1'b0;
					slot_has_tick[idx] = 1'b0;
				end
			endcase
		end
		return res;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(99);
		if (steady || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Handle of a slot in use, or a random one when the pool is empty
	function automatic logic [HANDLE_W-1:0] pick_live_handle();
		int start;
		int k;
		int idx;
		start = $urandom_range(POOL_SLOTS - 1);
		for (k = 0; k < POOL_SLOTS; k++) begin
			idx = (start + k) % POOL_SLOTS;
			if (slot_used[idx])
				return HANDLE_W'(idx + 1);
		end
		return HANDLE_W'($urandom_range(127));
	endfunction

	function automatic logic [TICK_W-1:0] pick_tick();
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return '0;
		if (roll < 16)
			return TICK_MAX;
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		fail_count++;
	endtask

	// Present one command and hold it until the transaction completes
	task automatic drive_cmd(cmd_t command, logic [HANDLE_W-1:0] handle,
		logic [TICK_W-1:0] tick);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= command;
		cmd_ch.query_handle <= handle;
		cmd_ch.tick_value   <= tick;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// Drive one command and queue the result the shadow pool predicts
	task automatic send_predicted(cmd_t command, logic [HANDLE_W-1:0] handle,
		logic [TICK_W-1:0] tick);
		drive_cmd(command, handle, tick);
		pending_results.insert(pending_results.size(), pool_apply(command, handle, tick));
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Limit on run time
	initial begin
		#20ms;
		$display("timestamp_query_slot_pool_core regression: fail");
		$finish;
	end

	// Result side: stall at random and check each transaction
	initial begin
		int stall;
		pool_result_t want;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: status %0d",
						rsp_ch.status));
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp_ch.status, want.status));
					if (rsp_ch.new_handle !== want.handle)
						report_mismatch($sformatf("new_handle %0d, want %0d",
							rsp_ch.new_handle, want.handle));
					if (rsp_ch.resolved_tick !== want.tick)
						report_mismatch($sformatf("resolved_tick %h, want %h",
							rsp_ch.resolved_tick, want.tick));
				end
			end
			if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				stall = idle_len();
				rsp_ch.ready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	// Stimulus
	initial begin
		int          mode;
		int          roll;
		int          burst;
		int unsigned sent;
		cmd_t        command;
		logic [HANDLE_W-1:0] handle;
		pool_result_t predicted;

		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.command      = CMD_CREATE;
		cmd_ch.query_handle = '0;
		cmd_ch.tick_value   = '0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			slot_used[i]     = 1'b0;
			slot_has_tick[i] = 1'b0;
			slot_ticks[i]    = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; rows marked given carry their own expectation
		foreach (directed_rows[i]) begin
			drive_cmd(directed_rows[i].command, directed_rows[i].handle,
				directed_rows[i].tick);
			predicted = pool_apply(directed_rows[i].command, directed_rows[i].handle,
				directed_rows[i].tick);
			if (directed_rows[i].given)
				pending_results.insert(pending_results.size(), directed_rows[i].result);
			else
				pending_results.insert(pending_results.size(), predicted);
		end

		// Fill the pool and push past full
		repeat (POOL_SLOTS + 3)
			send_predicted(CMD_CREATE, HANDLE_W'($urandom_range(127)), pick_tick());

		// Random bursts: grow, churn or drain the pool
		sent = 0;
		while (sent < RANDOM_CMDS) begin
			mode   = $urandom_range(2);
			steady = ($urandom_range(3) == 0);
			burst  = $urandom_range(20, 80);
			repeat (burst) begin
				roll = $urandom_range(99);
				case (mode)
					0: command = roll < 55 ? CMD_CREATE : roll < 72 ? CMD_RECORD :
						roll < 90 ? CMD_RESOLVE : CMD_DESTROY;
					1: command = cmd_t'(roll % 4);
					default: command = roll < 10 ? CMD_CREATE : roll < 30 ? CMD_RECORD :
						roll < 50 ? CMD_RESOLVE : CMD_DESTROY;
				endcase
				roll = $urandom_range(99);
				if (roll < 80)
					handle = pick_live_handle();
				else if (roll < 90)
					handle = HANDLE_W'($urandom_range(127));
				else
					handle = HANDLE_W'($urandom_range(1, POOL_SLOTS));
				send_predicted(command, handle, pick_tick());
				sent++;
			end
		end
		steady = 1'b0;

		// Drain and let the pipeline settle
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("timestamp_query_slot_pool_core regression: pass");
		else
			$display("timestamp_query_slot_pool_core regression: fail");
		$finish;
	end

endmodule
